>>> src/gma_pkg.sv
// shared types, constants and group decode for the grouped median age unit
package gma_pkg;

   // default store capacity in records
   localparam int MAX_RECORDS_DEFAULT = 256;

   // age and field widths
   localparam int AGE_W   = 7;
   localparam int GROUP_W = 3;
   localparam int SIZE_W  = 9;
   localparam int BIT_W   = 3;

   // group codes in result order
   localparam logic [GROUP_W-1:0] GRP_ALL          = 3'd0;
   localparam logic [GROUP_W-1:0] GRP_FEMALE       = 3'd1;
   localparam logic [GROUP_W-1:0] GRP_MALE         = 3'd2;
   localparam logic [GROUP_W-1:0] GRP_FEMALE_EMP   = 3'd3;
   localparam logic [GROUP_W-1:0] GRP_FEMALE_UNEMP = 3'd4;
   localparam logic [GROUP_W-1:0] GRP_MALE_EMP     = 3'd5;
   localparam logic [GROUP_W-1:0] GRP_MALE_UNEMP   = 3'd6;

   // top bit position of the age
   localparam logic [BIT_W-1:0] AGE_TOP_BIT = 3'd6;

   // input word
   typedef struct packed {
      logic [AGE_W-1:0] age;
      logic             is_female;
      logic             has_job;
      logic             last_record;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [GROUP_W-1:0] group_code;
      logic [AGE_W-1:0]   median_age;
      logic [SIZE_W-1:0]  group_size;
      logic               truncated;
      logic               last_result;
   } rsp_word_type;

   // one stored record
   typedef struct packed {
      logic             employed;
      logic             female;
      logic [AGE_W-1:0] age;
   } rec_type;

   // sequencer to selection unit
   typedef struct packed {
      logic               clear;
      logic               accum;
      logic               decide;
      logic               size_pass;
      logic [BIT_W-1:0]   bit_idx;
      logic [GROUP_W-1:0] group;
   } sel_ctrl_type;

   // group membership of a record
   function automatic logic in_group(input logic [GROUP_W-1:0] g,
                                     input logic fem, input logic emp);
      logic hit;
      case (g)
         GRP_ALL:          hit = 1'b1;
         GRP_FEMALE:       hit = fem;
         GRP_MALE:         hit = !fem;
         GRP_FEMALE_EMP:   hit = fem && emp;
         GRP_FEMALE_UNEMP: hit = fem && !emp;
         GRP_MALE_EMP:     hit = !fem && emp;
         default:          hit = !fem && !emp;
      endcase
      return hit;
   endfunction

endpackage

>>> src/grouped_median_age_unit.sv
// top level: record loading, pass sequencer and result register
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  req_word  (age, is_female, has_job, last_record)
//   rsp      out        rsp_valid / rsp_stall  rsp_word  (group_code, median_age, group_size,
//                                                         truncated, last_result)
//
// records load at one per cycle while no run is in progress.
// after the last record each of the seven groups takes 8 passes over the store
// (one size pass, one pass per age bit), each pass reading every stored record and
// ending in a decide step; an empty group takes only the size pass.
// the store's single registered read port sets the pass length.
// reset empties the record count and the overflow flag; the store itself is not cleared.
// req_stall is high for the whole run; a stalled result holds the sequencer in its emit step.
module grouped_median_age_unit
   import gma_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

   // sequencer states
   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_PASS   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic               size_pass_ff, size_pass_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               wr_en;
   logic               issue;
   rec_type            wr_data;
   rec_type            rd_data;
   sel_ctrl_type       ctrl;
   logic               cnt_zero;
   logic [AGE_W-1:0]   median;
   logic [CW-1:0]      size;
   logic [CW+SIZE_W-1:0] size_wide;

   assign wr_data = '{employed: req_word.has_job, female: req_word.is_female,
                      age: req_word.age};
   assign size_wide = {{SIZE_W{1'b0}}, size};

   gma_store #(.MAX_RECORDS(MAX_RECORDS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   gma_select #(.MAX_RECORDS(MAX_RECORDS)) u_select (
      .clock    (clock),
      .ctrl     (ctrl),
      .rec      (rd_data),
      .cnt_zero (cnt_zero),
      .median   (median),
      .size     (size)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      issue_in     = issue_ff;
      group_in     = group_ff;
      bit_in       = bit_ff;
      size_pass_in = size_pass_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      issue        = 1'b0;
      ctrl         = '{clear: 1'b0, accum: 1'b0, decide: 1'b0, size_pass: size_pass_ff,
                       bit_idx: bit_ff, group: group_ff};

      // result word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < MAX_CNT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_word.last_record) begin
                  state_in     = ST_PASS;
                  group_in     = GRP_ALL;
                  size_pass_in = 1'b1;
                  issue_in     = '0;
                  ctrl.clear   = 1'b1;
               end
            end
         end
         ST_PASS: begin
            ctrl.accum = rd_valid_ff;
            if (issue_ff != count_ff) begin
               issue    = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ctrl.decide = 1'b1;
            ctrl.clear  = 1'b1;
            issue_in    = '0;
            if (size_pass_ff) begin
               if (cnt_zero) begin
                  state_in = ST_EMIT;
               end else begin
                  size_pass_in = 1'b0;
                  bit_in       = AGE_TOP_BIT;
                  state_in     = ST_PASS;
               end
            end else if (bit_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_PASS;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{group_code: group_ff, median_age: median,
                                group_size: size_wide[SIZE_W-1:0], truncated: overflow_ff,
                                last_result: (group_ff == GRP_MALE_UNEMP)};
               if (group_ff == GRP_MALE_UNEMP) begin
                  state_in    = ST_LOAD;
                  count_in    = '0;
                  overflow_in = 1'b0;
               end else begin
                  group_in     = group_ff + 1'b1;
                  size_pass_in = 1'b1;
                  issue_in     = '0;
                  state_in     = ST_PASS;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rd_valid_in = issue;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         group_ff     <= GRP_ALL;
         bit_ff       <= '0;
         size_pass_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         group_ff     <= group_in;
         bit_ff       <= bit_in;
         size_pass_ff <= size_pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> src/gma_store.sv
// record store: one write port, one registered read port
module gma_store
   import gma_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEFAULT,
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rec_type       wr_data,
   input  logic [AW-1:0] rd_addr,
   output rec_type       rd_data
);

   rec_type store_ff [MAX_RECORDS];
   rec_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gma_select.sv
// bitwise median selection: counts matching records per pass, settles one age bit per pass
module gma_select
   import gma_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEFAULT,
   localparam int CW = $clog2(MAX_RECORDS + 1)
) (
   input  logic             clock,
   input  sel_ctrl_type     ctrl,
   input  rec_type          rec,
   output logic             cnt_zero,
   output logic [AGE_W-1:0] median,
   output logic [CW-1:0]    size
);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [AGE_W-1:0] prefix_ff, prefix_in;

   logic [AGE_W:0]   hi_mask_wide;
   logic [AGE_W-1:0] hi_mask;
   logic             grp_hit;
   logic             prefix_hit;
   logic             match;

   // record match for the current pass
   always_comb begin
      hi_mask_wide = {(AGE_W+1){1'b1}} << ({1'b0, ctrl.bit_idx} + 4'd1);
      hi_mask      = hi_mask_wide[AGE_W-1:0];
      grp_hit      = in_group(ctrl.group, rec.female, rec.employed);
      prefix_hit   = ((rec.age & hi_mask) == (prefix_ff & hi_mask)) && !rec.age[ctrl.bit_idx];
      match        = grp_hit && (ctrl.size_pass || prefix_hit);
   end

   // counter, target rank and prefix update
   always_comb begin
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      prefix_in = prefix_ff;
      if (ctrl.accum && match) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (ctrl.decide) begin
         if (ctrl.size_pass) begin
            n_in      = cnt_ff;
            k_in      = cnt_ff >> 1;
            prefix_in = '0;
         end else if (k_ff >= cnt_ff) begin
            prefix_in[ctrl.bit_idx] = 1'b1;
            k_in                    = k_ff - cnt_ff;
         end
      end
      if (ctrl.clear) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      prefix_ff <= prefix_in;
   end

   assign cnt_zero = (cnt_ff == '0);
   assign median   = prefix_ff;
   assign size     = n_ff;

endmodule
